// ----- hdl/cmbs_pkg.sv -----
package cmbs_pkg;

  localparam int unsigned LatW = 29;
  localparam int unsigned LonW = 30;
  localparam int unsigned RowW = 11;   // lat / 300000 stays below 1790
  localparam int unsigned ColW = 12;   // lon / 450000 stays below 2387
  localparam int unsigned RemW = 19;
  localparam int unsigned DegW = ColW - 3;

  localparam longint unsigned RowMas = 300000;
  localparam longint unsigned ColMas = 450000;
  localparam longint unsigned NudgeMas = 36;
  localparam longint unsigned SnapMas = 12;
  localparam longint unsigned LonOriginDeg = 60;
  localparam longint unsigned BandMax = 99;
  localparam longint unsigned LonBandSat = 127;

  // Reciprocals rounded up; the rounding error stays below one for every
  // input code, so the high product bits are the exact quotient.
  localparam int unsigned RowShift = 48;
  localparam int unsigned ColShift = 49;
  localparam int unsigned RowRecipW = 30;
  localparam int unsigned ColRecipW = 31;
  localparam logic [RowRecipW-1:0] RowRecip =
    RowRecipW'(((64'd1 << RowShift) + RowMas - 64'd1) / RowMas);
  localparam logic [ColRecipW-1:0] ColRecip =
    ColRecipW'(((64'd1 << ColShift) + ColMas - 64'd1) / ColMas);

  typedef struct packed {
    logic [LatW-1:0] lat_mas;
    logic [LonW-1:0] lon_mas;
  } req_t;

  typedef struct packed {
    logic              code_error;
    logic [7:0]        lat_band;
    logic signed [7:0] lon_band;
    logic [2:0]        row_digit;
    logic [2:0]        col_digit;
    logic              on_border;
  } rsp_t;

  typedef struct packed {
    logic [LatW-1:0] lat_mas;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } quot_t;

  // Residue of an 11-bit value modulo 3: each bit pair is worth itself mod 3.
  function automatic logic [1:0] mod3(input logic [RowW-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[10]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

// ----- hdl/coordinate_to_mesh_code_with_border_snap_core.sv -----
// Map sheet code locator. A point in milliarcseconds is taken on every clock
// edge where start_i is high; busy_o stays low, so a new word can follow each
// cycle. The result passes through the input register, the reciprocal-multiply
// quotient register and the result register, and sits on rsp_o for exactly
// one cycle with done_o high. There is no backpressure: the receiver must take
// every word in the cycle it is shown.
module coordinate_to_mesh_code_with_border_snap_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  cmbs_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output cmbs_pkg::rsp_t rsp_o
);
  import cmbs_pkg::*;

  req_t  req_q;
  logic  in_valid_q;
  logic  quot_valid;
  quot_t quot;
  logic  accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  cmbs_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .req_i   (req_q),
    .valid_o (quot_valid),
    .quot_o  (quot)
  );

  cmbs_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (quot_valid),
    .quot_i  (quot),
    .valid_o (done_o),
    .rsp_o   (rsp_o)
  );

  // Every result word comes from a word accepted earlier.
  a_done_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 3))
    else $error("result word without a matching start");

  // A valid code has both bands inside the table.
  a_code_ok_bands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.code_error) |->
      (rsp_o.lat_band <= 8'd99 && !rsp_o.lon_band[7] && rsp_o.lon_band <= 8'sd99))
    else $error("code marked valid with a band out of range");

  // West of the origin the column digit is forced to zero and the code is bad.
  a_west_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.lon_band[7]) |-> (rsp_o.col_digit == 3'd0 && rsp_o.code_error))
    else $error("negative longitude band with column digit or valid code");

endmodule

// ----- hdl/cmbs_quot.sv -----
module cmbs_quot (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  cmbs_pkg::req_t req_i,
  output logic           valid_o,
  output cmbs_pkg::quot_t quot_o
);
  import cmbs_pkg::*;

  localparam int unsigned LatProdW = LatW + RowRecipW;
  localparam int unsigned LonProdW = LonW + ColRecipW;

  logic [LatProdW-1:0] lat_prod;
  logic [LonProdW-1:0] lon_prod;
  quot_t               quot_d, quot_q;
  logic                valid_q;

  assign lat_prod = LatProdW'(req_i.lat_mas) * LatProdW'(RowRecip);
  assign lon_prod = LonProdW'(req_i.lon_mas) * LonProdW'(ColRecip);

  always_comb begin
    quot_d.lat_mas = req_i.lat_mas;
    quot_d.row     = lat_prod[RowShift +: RowW];
    quot_d.col     = lon_prod[ColShift +: ColW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign valid_o = valid_q;
  assign quot_o  = quot_q;

endmodule

// ----- hdl/cmbs_digits.sv -----
module cmbs_digits (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cmbs_pkg::quot_t quot_i,
  output logic            valid_o,
  output cmbs_pkg::rsp_t  rsp_o
);
  import cmbs_pkg::*;

  localparam int unsigned BaseW = LatW + 1;

  logic [BaseW-1:0] row_base;
  logic [BaseW-1:0] rem_full;
  logic [RemW-1:0]  rem;
  logic [1:0]       pos;
  logic             nudge;
  logic [RemW:0]    rem_n;
  logic             wrap;
  logic [RemW-1:0]  rem2;
  logic [RowW-1:0]  row2;
  logic [1:0]       pos2;
  logic             snap_up;
  logic             snap_dn;
  logic [DegW-1:0]  deg;
  logic [DegW-1:0]  lon_off;
  logic             west;
  rsp_t             rsp_d, rsp_q;
  logic             valid_q;

  assign row_base = BaseW'(quot_i.row) * BaseW'(RowMas);
  assign rem_full = BaseW'(quot_i.lat_mas) - row_base;
  assign rem      = rem_full[RemW-1:0];
  assign pos      = mod3(quot_i.row);

  // Exactly on the bottom border of a triple, or exactly on the edge of a snap window next to its middle row.
  assign nudge = ((pos == 2'd0) && ((rem == '0) || (rem == RemW'(RowMas - SnapMas)))) ||
                 ((pos == 2'd2) && (rem == RemW'(SnapMas)));

  assign rem_n = nudge ? ((RemW + 1)'(rem) + (RemW + 1)'(NudgeMas)) : (RemW + 1)'(rem);
  assign wrap  = rem_n >= (RemW + 1)'(RowMas);
  assign rem2  = wrap ? RemW'(rem_n - (RemW + 1)'(RowMas)) : rem_n[RemW-1:0];
  assign row2  = quot_i.row + RowW'(wrap);

  always_comb begin
    pos2 = pos;
    if (wrap) begin
      pos2 = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
    end
  end

  assign snap_up = (pos2 == 2'd0) && (rem2 >= RemW'(RowMas - SnapMas));
  assign snap_dn = (pos2 == 2'd2) && (rem2 < RemW'(SnapMas));

  // 3600000 mas is eight columns, so the degree is the column index over 8.
  assign deg     = quot_i.col[ColW-1:3];
  assign lon_off = deg - DegW'(LonOriginDeg);
  assign west    = deg < DegW'(LonOriginDeg);

  always_comb begin
    rsp_d.on_border = nudge;
    rsp_d.lat_band  = row2[RowW-1:3];
    if (snap_up) begin
      rsp_d.row_digit = row2[2:0] + 3'd1;
    end else if (snap_dn) begin
      rsp_d.row_digit = row2[2:0] - 3'd1;
    end else begin
      rsp_d.row_digit = row2[2:0];
    end
    rsp_d.col_digit = west ? 3'd0 : quot_i.col[2:0];
    if (deg > DegW'(LonOriginDeg + LonBandSat)) begin
      rsp_d.lon_band = 8'(LonBandSat);
    end else begin
      rsp_d.lon_band = lon_off[7:0];
    end
    rsp_d.code_error = (row2[RowW-1:3] > 8'(BandMax)) || west ||
                       (deg > DegW'(LonOriginDeg + BandMax));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import cmbs_pkg::*;

  localparam longint unsigned DegMas = 3600000;
  localparam longint unsigned LatBandMas = 2400000;
  localparam longint unsigned LonOriginMas = LonOriginDeg * DegMas;
  localparam longint unsigned LatHigh = 324000000;
  localparam longint unsigned LonHigh = 648000000;
  localparam int unsigned RandomWords = 1700;
  localparam int unsigned QuietWords = 250;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit = 200000;

  // Holds the sheet codes still owed by the block, oldest first.
  class sheet_scoreboard;
    rsp_t        sheet_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function rsp_t locate_sheet(req_t w);
      longint unsigned lat;
      longint unsigned lon;
      longint unsigned row;
      longint unsigned rem;
      longint signed   band;
      rsp_t            r;
      r   = '0;
      lat = w.lat_mas;
      lon = w.lon_mas;
      row = lat / RowMas;
      rem = lat % RowMas;
      r.on_border = ((row % 3 == 0) && (rem == 0 || rem == RowMas - SnapMas)) ||
                    ((row % 3 == 2) && (rem == SnapMas));
      if (r.on_border) begin
        lat = lat + NudgeMas;
      end
      // The snap works on the nudged latitude with its own remainder.
      row = lat / RowMas;
      rem = lat % RowMas;
      if (row % 3 == 0 && rem >= RowMas - SnapMas) begin
        row = row + 1;
      end else if (row % 3 == 2 && rem < SnapMas) begin
        row = row - 1;
      end
      r.row_digit = row[2:0];
      r.lat_band  = 8'(lat / LatBandMas);
      band = longint'(lon / DegMas) - longint'(LonOriginDeg);
      if (lon >= LonOriginMas) begin
        r.col_digit = 3'((lon - LonOriginMas) / ColMas);
      end
      r.code_error = (lat / LatBandMas > BandMax) || (band > longint'(BandMax)) || (band < 0);
      if (band > longint'(LonBandSat)) begin
        band = longint'(LonBandSat);
      end
      r.lon_band = 8'(band);
      return r;
    endfunction

    function void note_word(req_t w);
      sheet_q = {sheet_q, locate_sheet(w)};
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(rsp_t got);
      rsp_t exp_w;
      if (sheet_q.size() == 0) begin
        $error("result word with no point waiting for it");
        errors++;
        return;
      end
      exp_w = sheet_q.pop_front();
      compare_field("code_error", int'(exp_w.code_error), int'(got.code_error));
      compare_field("lat_band", int'(exp_w.lat_band), int'(got.lat_band));
      compare_field("lon_band", int'(exp_w.lon_band), int'(got.lon_band));
      compare_field("row_digit", int'(exp_w.row_digit), int'(got.row_digit));
      compare_field("col_digit", int'(exp_w.col_digit), int'(got.col_digit));
      compare_field("on_border", int'(exp_w.on_border), int'(got.on_border));
    endfunction

    function int unsigned pending();
      return sheet_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  sheet_scoreboard sb;

  coordinate_to_mesh_code_with_border_snap_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL coordinate_to_mesh_code_with_border_snap_core");
    $finish;
  end

  // Both sides are sampled with their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (start_i && !busy_o) begin
        sb.note_word(req_i);
      end
      if (done_o) begin
        sb.check_word(rsp_o);
      end
    end
  end

  task automatic send_point(input longint unsigned lat, input longint unsigned lon,
                            input bit may_idle);
    req_t w;
    w.lat_mas = LatW'(lat);
    w.lon_mas = LonW'(lon);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= w;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Mostly points close to the edges of a row, where nudge and snap act.
  function automatic longint unsigned pick_lat();
    longint unsigned row;
    longint unsigned off;
    int              sel;
    int              near_offs[12] = '{0, 5, 11, 12, 13, 24, 35, 36, 48,
                                       299976, 299988, 299999};
    sel = $urandom_range(0, 9);
    row = $urandom_range(0, 1079);
    if (sel <= 3) begin
      off = near_offs[$urandom_range(0, 11)];
      return row * RowMas + off;
    end else if (sel == 4) begin
      off = $urandom_range(0, 60);
      return (row + 1) * RowMas - off;
    end else if (sel == 5) begin
      return row * RowMas + $urandom_range(0, 60);
    end else if (sel == 6) begin
      return 64'($urandom) & ((64'd1 << LatW) - 1);
    end else if (sel == 7) begin
      return 100 * LatBandMas - 40 + $urandom_range(0, 80);
    end
    return $urandom_range(0, 32'(LatHigh));
  endfunction

  function automatic longint unsigned pick_lon();
    longint unsigned base;
    int              sel;
    sel = $urandom_range(0, 9);
    if (sel <= 2) begin
      base = longint'($urandom_range(1, 189)) * DegMas;
      return base - 3 + $urandom_range(0, 6);
    end else if (sel <= 4) begin
      base = LonOriginMas + longint'($urandom_range(0, 960)) * ColMas;
      return base - 3 + $urandom_range(0, 6);
    end else if (sel == 5) begin
      return 64'($urandom) & ((64'd1 << LonW) - 1);
    end else if (sel == 6) begin
      return $urandom_range(0, 32'(LonOriginMas));
    end
    return $urandom_range(0, 32'(LonHigh));
  endfunction

  initial begin
    longint unsigned all_lat;
    longint unsigned all_lon;
    all_lat = (64'd1 << LatW) - 1;
    all_lon = (64'd1 << LonW) - 1;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes.
    send_point(0, 0, 1'b0);
    send_point(all_lat, all_lon, 1'b0);
    send_point(LatHigh, LonHigh, 1'b0);
    // Longitude around the origin, the last valid band, saturation and a degree edge.
    send_point(1000000, LonOriginMas, 1'b0);
    send_point(1000000, LonOriginMas - 1, 1'b1);
    send_point(1000000, 160 * DegMas - 1, 1'b0);
    send_point(1000000, 160 * DegMas, 1'b0);
    send_point(1000000, 188 * DegMas - 1, 1'b1);
    send_point(1000000, 188 * DegMas, 1'b0);
    send_point(1000000, LonOriginMas + 8 * ColMas - 1, 1'b0);
    send_point(1000000, LonOriginMas + 8 * ColMas, 1'b0);
    // Horizontal borders at the bottom of a triple, its top and its middle row.
    send_point(3 * RowMas, 250000000, 1'b0);
    send_point(4 * RowMas - SnapMas, 250000000, 1'b1);
    send_point(2 * RowMas + SnapMas, 250000000, 1'b0);
    send_point(RowMas, 250000000, 1'b0);
    // Snap without a nudge, both directions, and just outside the window.
    send_point(4 * RowMas - 10, 250000000, 1'b0);
    send_point(4 * RowMas - 13, 250000000, 1'b0);
    send_point(2 * RowMas + 5, 250000000, 1'b0);
    send_point(2 * RowMas + 11, 250000000, 1'b1);
    send_point(2 * RowMas + 13, 250000000, 1'b0);
    // Latitude band limit and points just below it.
    send_point(100 * LatBandMas - 1, 250000000, 1'b0);
    send_point(100 * LatBandMas, 250000000, 1'b0);
    send_point(100 * LatBandMas - SnapMas, 250000000, 1'b0);
    send_point(0, 100000000, 1'b0);

    for (int i = 0; i < RandomWords; i++) begin
      send_point(pick_lat(), pick_lon(), i < RandomWords - QuietWords);
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS coordinate_to_mesh_code_with_border_snap_core");
    end else begin
      $display("FAIL coordinate_to_mesh_code_with_border_snap_core");
    end
    $finish;
  end

endmodule
